// ===== design/bidirectional_door_passenger_counter_core_assert.svh =====
// Assertion macros for the passenger counter core.
// Needs clk_i and rst_ni in the scope of the including module.
`ifndef BIDIRECTIONAL_DOOR_PASSENGER_COUNTER_CORE_ASSERT_SVH
`define BIDIRECTIONAL_DOOR_PASSENGER_COUNTER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BDPC_ASSERT_NOW(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BDPC_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/bdpc_pkg.sv =====
// Shared types and constants of the passenger counter core.
// No dependencies; used by the channel interfaces and the core.
package bdpc_pkg;

  localparam int NUM_DOORS  = 2;
  localparam int DOOR_IDX_W = (NUM_DOORS > 1) ? $clog2(NUM_DOORS) : 1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [9:0]  THRESHOLD_RST = 10'd23;
  localparam logic [15:0] TIMEOUT_RST   = 16'd4000;
  localparam logic [15:0] HOLD_RST      = 16'd300;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_TIMEOUT   = 2'd1,
    REG_HOLD      = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    OP_SAMPLE     = 1'b0,
    OP_CLEAR_FLAG = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    PH_IDLE        = 3'd0,
    PH_ENTRY_START = 3'd1,
    PH_EXIT_START  = 3'd2,
    PH_ENTRY_HALF  = 3'd3,
    PH_EXIT_HALF   = 3'd4,
    PH_CLEARING    = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_ENTER = 2'd1,
    EV_EXIT  = 2'd2
  } event_e;

  typedef struct packed {
    logic        op;
    logic        door;
    logic [9:0]  outer_cm;
    logic [9:0]  inner_cm;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [15:0] passenger_count;
    logic        count_updated;
    logic [2:0]  door_phase;
    logic [1:0]  event_res;
  } out_item_t;

  // One per-door entry of the state memory.
  typedef struct packed {
    phase_e      phase;
    logic [31:0] phase_start;
    logic [31:0] clear_start;
  } door_entry_t;

endpackage

// ===== design/bdpc_if.sv =====
// Valid/ready channel interfaces for input and result items.
// Depends on bdpc_pkg for the payload types.
interface bdpc_in_if
  import bdpc_pkg::*;
;
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bdpc_out_if
  import bdpc_pkg::*;
;
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/bidirectional_door_passenger_counter_core.sv =====
// Two-beam bidirectional passenger counter with per-door crossing state.
// Result path: door entry read into stage 1 at accept, result registered when stage 1 advances.
// Throughput: 1 item per cycle while the output is not stalled; set by the per-door
//   entry read/write-back, with a bypass when consecutive items hit the same door.
// Reset: async active low; count, flag, valid bits and handshake cleared, config set to
//   its reset values; a door entry that was never written reads as idle with zero stamps.
module bidirectional_door_passenger_counter_core
  import bdpc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  bdpc_in_if.sink               in_if,
  bdpc_out_if.source            out_if
);

`include "bidirectional_door_passenger_counter_core_assert.svh"

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [9:0]  thresh_q;
  logic [15:0] timeout_q;
  logic [15:0] hold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q  <= THRESHOLD_RST;
      timeout_q <= TIMEOUT_RST;
      hold_q    <= HOLD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_THRESHOLD: thresh_q  <= cfg_data_i[9:0];
        REG_TIMEOUT:   timeout_q <= cfg_data_i;
        REG_HOLD:      hold_q    <= cfg_data_i;
        default:       ;  // index beyond the register list: drop the write
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: stage 1 holds the item whose door entry was just read,
  // the output register holds a finished result.
  // ---------------------------------------------------------------------------
  logic        s1_vld_q;
  in_item_t    s1_item_q;
  logic        out_vld_q;
  out_item_t   out_q;
  logic        s1_adv;
  logic        in_fire;

  assign s1_adv      = s1_vld_q && (!out_vld_q || out_if.ready);
  assign in_if.ready = !s1_vld_q || s1_adv;
  assign in_fire     = in_if.valid && in_if.ready;

  assign out_if.valid = out_vld_q;
  assign out_if.data  = out_q;

  // ---------------------------------------------------------------------------
  // Per-door state memory: one read port at accept, one write port at retire.
  // ---------------------------------------------------------------------------
  door_entry_t             door_mem [NUM_DOORS];
  logic [NUM_DOORS-1:0]    ent_vld_q;
  door_entry_t             rd_q;
  door_entry_t             wr_entry;
  logic                    wr_en;
  logic [DOOR_IDX_W-1:0]   wr_idx;
  logic [DOOR_IDX_W-1:0]   rd_idx;
  logic                    s1_in_range;

  assign rd_idx      = DOOR_IDX_W'(in_if.data.door);
  assign wr_idx      = DOOR_IDX_W'(s1_item_q.door);
  assign s1_in_range = (32'(s1_item_q.door) < NUM_DOORS);
  assign wr_en       = s1_adv && (op_e'(s1_item_q.op) == OP_SAMPLE) && s1_in_range;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      door_mem[wr_idx] <= wr_entry;
    end
  end

  // Registered read; bypass the write that retires on the same edge,
  // and read an unwritten entry as its reset value.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      if (wr_en && (wr_idx == rd_idx)) begin
        rd_q <= wr_entry;
      end else if (ent_vld_q[rd_idx]) begin
        rd_q <= door_mem[rd_idx];
      end else begin
        rd_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= '0;
    end else if (wr_en) begin
      ent_vld_q[wr_idx] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1 update: phase transitions, count, flag, timeout.
  // ---------------------------------------------------------------------------
  logic [15:0] count_q, count_d;
  logic        flag_q, flag_d;
  phase_e      ph_d;
  logic [31:0] ps_d, cs_d;
  event_e      ev;
  logic [2:0]  res_phase;
  logic        ob, ib;
  logic [31:0] clr_elapsed, ph_elapsed;
  logic        began_crossing;

  assign ob = s1_item_q.outer_cm < thresh_q;
  assign ib = s1_item_q.inner_cm < thresh_q;
  assign clr_elapsed = s1_item_q.now_ms - rd_q.clear_start;
  assign ph_elapsed  = s1_item_q.now_ms - ps_d;
  assign began_crossing = (rd_q.phase == PH_ENTRY_START) || (rd_q.phase == PH_EXIT_START) ||
                          (rd_q.phase == PH_ENTRY_HALF)  || (rd_q.phase == PH_EXIT_HALF);

  always_comb begin
    ph_d      = rd_q.phase;
    ps_d      = rd_q.phase_start;
    cs_d      = rd_q.clear_start;
    ev        = EV_NONE;
    count_d   = count_q;
    flag_d    = flag_q;
    res_phase = 3'(PH_IDLE);

    if (op_e'(s1_item_q.op) == OP_CLEAR_FLAG) begin
      flag_d = 1'b0;
      if (s1_in_range) begin
        res_phase = 3'(rd_q.phase);
      end
    end else if (s1_in_range) begin
      unique case (rd_q.phase)
        PH_IDLE: begin
          if (ob && !ib) begin
            ph_d = PH_ENTRY_START;
            ps_d = s1_item_q.now_ms;
          end else if (ib && !ob) begin
            ph_d = PH_EXIT_START;
            ps_d = s1_item_q.now_ms;
          end
        end
        PH_ENTRY_START: begin
          if (ib) begin
            ph_d = PH_ENTRY_HALF;
            ps_d = s1_item_q.now_ms;
          end
        end
        PH_EXIT_START: begin
          if (ob) begin
            ph_d = PH_EXIT_HALF;
            ps_d = s1_item_q.now_ms;
          end
        end
        PH_ENTRY_HALF: begin
          if (ob && !ib) begin
            // stepped back: fall back to entry started
            ph_d = PH_ENTRY_START;
            ps_d = s1_item_q.now_ms;
          end else if (!ob && !ib) begin
            if (count_q != 16'hFFFF) begin
              count_d = count_q + 16'd1;
            end
            flag_d = 1'b1;
            ev     = EV_ENTER;
            ph_d   = PH_CLEARING;
            cs_d   = s1_item_q.now_ms;
          end
        end
        PH_EXIT_HALF: begin
          if (ib && !ob) begin
            ph_d = PH_EXIT_START;
            ps_d = s1_item_q.now_ms;
          end else if (!ob && !ib) begin
            if (count_q != 16'd0) begin
              count_d = count_q - 16'd1;
            end
            flag_d = 1'b1;
            ev     = EV_EXIT;
            ph_d   = PH_CLEARING;
            cs_d   = s1_item_q.now_ms;
          end
        end
        default: begin
          // clearing: wait until both beams stay clear past the hold time
          if (!ob && !ib) begin
            if (clr_elapsed > 32'(hold_q)) begin
              ph_d = PH_IDLE;
            end
          end else begin
            cs_d = s1_item_q.now_ms;
          end
        end
      endcase

      // Timeout runs last and may undo a fresh count's clearing phase.
      if (began_crossing && (ph_elapsed > 32'(timeout_q))) begin
        ph_d = PH_IDLE;
      end
      res_phase = 3'(ph_d);
    end
  end

  always_comb begin
    wr_entry.phase       = ph_d;
    wr_entry.phase_start = ps_d;
    wr_entry.clear_start = cs_d;
  end

  // ---------------------------------------------------------------------------
  // Control and payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      count_q   <= '0;
      flag_q    <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_vld_q <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_q <= 1'b0;
      end
      if (s1_adv) begin
        out_vld_q <= 1'b1;
        count_q   <= count_d;
        flag_q    <= flag_d;
      end else if (out_if.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q <= in_if.data;
    end
    if (s1_adv) begin
      out_q.passenger_count <= count_d;
      out_q.count_updated   <= flag_d;
      out_q.door_phase      <= res_phase;
      out_q.event_res       <= 2'(ev);
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `BDPC_ASSERT_NEXT(a_count_only_on_event, !(s1_adv && (ev != EV_NONE)), $stable(count_q), "count changed without an event")
  `BDPC_ASSERT_NOW(a_event_phase, out_vld_q && (out_q.event_res != 2'(EV_NONE)), (out_q.door_phase == 3'(PH_CLEARING)) || (out_q.door_phase == 3'(PH_IDLE)), "counted door not clearing or idle")
  `BDPC_ASSERT_NEXT(a_s1_holds_on_stall, s1_vld_q && out_vld_q && !out_if.ready, s1_vld_q, "stage 1 item lost during stall")
  `BDPC_ASSERT_NEXT(a_flag_cleared, s1_adv && (op_e'(s1_item_q.op) == OP_CLEAR_FLAG), !flag_q, "update flag not cleared")

endmodule
